@@ rtl/lcm_pkg.sv @@
`timescale 1ns / 1ps
package lcm_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int PIX_W   = 8;
    localparam int LVL_W   = 7;
    localparam int GEOM_W  = 11;
    localparam int VAL_W   = 8;
    localparam int COORD_W = 10;

    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;
    localparam int REG_IW  = 3;

    localparam logic [REG_IW-1:0] REG_ROW_LENGTH = 3'd0;
    localparam logic [REG_IW-1:0] REG_ROW_TOTAL  = 3'd1;
    localparam logic [REG_IW-1:0] REG_EQUIDIST   = 3'd2;
    localparam logic [REG_IW-1:0] REG_CONTOUR    = 3'd3;
    localparam logic [REG_IW-1:0] REG_BACKGROUND = 3'd4;

    localparam logic [GEOM_W-1:0] ROW_LENGTH_RST = 11'd1024;
    localparam logic [GEOM_W-1:0] ROW_TOTAL_RST  = 11'd1024;
    localparam logic [VAL_W-1:0]  EQUIDIST_RST   = 8'd2;
    localparam logic [VAL_W-1:0]  CONTOUR_RST    = 8'd255;
    localparam logic [VAL_W-1:0]  BACKGROUND_RST = 8'd0;
    localparam logic [VAL_W-1:0]  EQUIDIST_MIN   = 8'd2;

    typedef struct packed {
        logic [GEOM_W-1:0] row_length;
        logic [GEOM_W-1:0] row_total;
        logic [VAL_W-1:0]  equidistance;
        logic [VAL_W-1:0]  contour_value;
        logic [VAL_W-1:0]  background_value;
    } cfg_t;

endpackage

@@ rtl/lcm_cfg.sv @@
`timescale 1ns / 1ps
module lcm_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcm_pkg::APB_AW-1:0]  paddr,
    input  logic [lcm_pkg::APB_DW-1:0]  pwdata,
    output logic [lcm_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output lcm_pkg::cfg_t               cfg
);
    import lcm_pkg::*;

    cfg_t              cfg_reg;
    cfg_t              cfg_next;
    logic [REG_IW-1:0] reg_idx;
    logic              wr_beat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_beat = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_beat)
        begin
            case (reg_idx)
                REG_ROW_LENGTH: cfg_next.row_length       = pwdata[GEOM_W-1:0];
                REG_ROW_TOTAL:  cfg_next.row_total        = pwdata[GEOM_W-1:0];
                REG_EQUIDIST:   cfg_next.equidistance     = pwdata[VAL_W-1:0];
                REG_CONTOUR:    cfg_next.contour_value    = pwdata[VAL_W-1:0];
                REG_BACKGROUND: cfg_next.background_value = pwdata[VAL_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            REG_ROW_LENGTH: prdata[GEOM_W-1:0] = cfg_reg.row_length;
            REG_ROW_TOTAL:  prdata[GEOM_W-1:0] = cfg_reg.row_total;
            REG_EQUIDIST:   prdata[VAL_W-1:0]  = cfg_reg.equidistance;
            REG_CONTOUR:    prdata[VAL_W-1:0]  = cfg_reg.contour_value;
            REG_BACKGROUND: prdata[VAL_W-1:0]  = cfg_reg.background_value;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_length       <= ROW_LENGTH_RST;
            cfg_reg.row_total        <= ROW_TOTAL_RST;
            cfg_reg.equidistance     <= EQUIDIST_RST;
            cfg_reg.contour_value    <= CONTOUR_RST;
            cfg_reg.background_value <= BACKGROUND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/lcm_div.sv @@
`timescale 1ns / 1ps
module lcm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lcm_pkg::PIX_W-1:0]  dividend,
    input  logic [lcm_pkg::VAL_W-1:0]  divisor,
    output logic                       done,
    output logic [lcm_pkg::LVL_W-1:0]  quotient
);
    import lcm_pkg::*;

    localparam int SW = $clog2(PIX_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SW-1:0]    cnt_reg, cnt_next;
    logic [VAL_W-1:0] dsr_reg, dsr_next;
    logic [PIX_W-1:0] dvd_reg, dvd_next;
    logic [VAL_W-1:0] rem_reg, rem_next;
    logic [LVL_W-1:0] quo_reg, quo_next;
    logic [VAL_W:0]   trial;
    logic             fits;

    // one quotient bit per cycle, msb first
    assign trial = {rem_reg, dvd_reg[PIX_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dsr_next  = dsr_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = SW'(PIX_W - 1);
            dsr_next  = divisor;
            dvd_next  = dividend;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? VAL_W'(trial - {1'b0, dsr_reg}) : trial[VAL_W-1:0];
            quo_next = {quo_reg[LVL_W-2:0], fits};
            dvd_next = {dvd_reg[PIX_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dsr_reg <= dsr_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/lcm_line.sv @@
`timescale 1ns / 1ps
module lcm_line #(
    parameter int DEPTH = lcm_pkg::DEF_MAX_WIDTH,
    parameter int AW    = $clog2(lcm_pkg::DEF_MAX_WIDTH)
) (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [lcm_pkg::LVL_W-1:0]  rd_data,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [lcm_pkg::LVL_W-1:0]  wr_data
);
    import lcm_pkg::*;

    logic [LVL_W-1:0] mem [DEPTH];
    logic [LVL_W-1:0] rd_data_reg;

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/level_contour_map.sv @@
`timescale 1ns / 1ps
// channel   dir  handshake                   payload
// s_*       in   s_tvalid / s_tready         s_tdata: pixel
// m_*       out  m_tvalid / m_tready         m_tdata: out_row, out_col, out_value; m_tlast
// apb       in   psel & penable & pwrite     paddr, pwdata, prdata (pready tied high)
//
// one pixel at a time: the beat is taken, its level comes out of an 8-step
// bit-serial divider, then decide writes it to the line memory entry read at accept
// an item gives 0..4 result beats
// result beats go out from a small result register set, stalled by m_tready
// reset clears counters, neighbor levels and control; line memory is not cleared
module level_contour_map #(
    parameter int MAX_WIDTH  = lcm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lcm_pkg::DEF_MAX_HEIGHT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lcm_pkg::APB_AW-1:0] paddr,
    input  logic [lcm_pkg::APB_DW-1:0] pwdata,
    output logic [lcm_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] pixel
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,   // [9:0] out_row, [19:10] out_col, [27:20] out_value
    output logic                       m_tlast
);
    import lcm_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XCW  = ((CW > GEOM_W) ? CW : GEOM_W) + 1;
    localparam int YCW  = ((RW > GEOM_W) ? RW : GEOM_W) + 1;
    localparam int NRES = 4;
    localparam int MPAD = 32 - 2 * COORD_W - VAL_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    cfg_t             cfg;
    logic [1:0]       state_reg, state_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [LVL_W-1:0] ul_reg, ul_next;
    logic [LVL_W-1:0] left_reg, left_next;
    logic [NRES-1:0]  pend_reg, pend_next;

    logic [RW-1:0]    res_row_reg [NRES];
    logic [CW-1:0]    res_col_reg [NRES];
    logic [VAL_W-1:0] res_val_reg [NRES];
    logic [RW-1:0]    res_row_next [NRES];
    logic [CW-1:0]    res_col_next [NRES];
    logic [VAL_W-1:0] res_val_next [NRES];

    logic             in_beat;
    logic             decide;
    logic             div_done;
    logic [LVL_W-1:0] cur_lvl;
    logic [LVL_W-1:0] up_lvl;
    logic [VAL_W-1:0] eq_eff;
    logic [XCW-1:0]   w_eff, x_ext, rl_ext;
    logic [YCW-1:0]   h_eff, y_ext, rt_ext;
    logic             last_col, last_row, has_up, has_left;
    logic [NRES-1:0]  new_pend;
    logic [NRES-1:0]  sel_mask;
    logic [1:0]       sel_idx;
    logic [RW+COORD_W-1:0] row_wide;
    logic [CW+COORD_W-1:0] col_wide;

    lcm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign decide   = (state_reg == S_DIV) && div_done;

    assign eq_eff = (cfg.equidistance < EQUIDIST_MIN) ? EQUIDIST_MIN : cfg.equidistance;

    lcm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_beat),
        .dividend (s_tdata[PIX_W-1:0]),
        .divisor  (eq_eff),
        .done     (div_done),
        .quotient (cur_lvl)
    );

    // read at accept, written back at decide; items never overlap
    lcm_line #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line (
        .clk     (clk),
        .rd_en   (in_beat),
        .rd_addr (col_reg),
        .rd_data (up_lvl),
        .wr_en   (decide),
        .wr_addr (col_reg),
        .wr_data (cur_lvl)
    );

    // clamped geometry
    always_comb
    begin
        rl_ext = {{(XCW-GEOM_W){1'b0}}, cfg.row_length};
        rt_ext = {{(YCW-GEOM_W){1'b0}}, cfg.row_total};
        if (rl_ext == '0)
            w_eff = XCW'(1);
        else if (rl_ext > XCW'(MAX_WIDTH))
            w_eff = XCW'(MAX_WIDTH);
        else
            w_eff = rl_ext;
        if (rt_ext == '0)
            h_eff = YCW'(1);
        else if (rt_ext > YCW'(MAX_HEIGHT))
            h_eff = YCW'(MAX_HEIGHT);
        else
            h_eff = rt_ext;
    end

    assign x_ext    = {{(XCW-CW){1'b0}}, col_reg};
    assign y_ext    = {{(YCW-RW){1'b0}}, row_reg};
    assign last_col = (x_ext + XCW'(1)) >= w_eff;
    assign last_row = (y_ext + YCW'(1)) >= h_eff;
    assign has_up   = (row_reg != '0);
    assign has_left = (col_reg != '0);
    assign new_pend = {last_row && last_col, last_row && has_left,
                       has_up && last_col, has_up && has_left};

    // results in order: upper-left, upper, left, current
    always_comb
    begin
        res_row_next[0] = row_reg - 1'b1;
        res_col_next[0] = col_reg - 1'b1;
        res_val_next[0] = ((ul_reg != up_lvl) || (ul_reg != left_reg)) ?
                          cfg.contour_value : cfg.background_value;
        res_row_next[1] = row_reg - 1'b1;
        res_col_next[1] = col_reg;
        res_val_next[1] = (up_lvl != cur_lvl) ? cfg.contour_value : cfg.background_value;
        res_row_next[2] = row_reg;
        res_col_next[2] = col_reg - 1'b1;
        res_val_next[2] = (left_reg != cur_lvl) ? cfg.contour_value : cfg.background_value;
        res_row_next[3] = row_reg;
        res_col_next[3] = col_reg;
        res_val_next[3] = cfg.background_value;
    end

    // lowest pending result goes first
    always_comb
    begin
        if (pend_reg[0])
            sel_idx = 2'd0;
        else if (pend_reg[1])
            sel_idx = 2'd1;
        else if (pend_reg[2])
            sel_idx = 2'd2;
        else
            sel_idx = 2'd3;
        sel_mask = NRES'(1) << sel_idx;
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        ul_next    = ul_reg;
        left_next  = left_reg;
        pend_next  = pend_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    pend_next  = new_pend;
                    state_next = (new_pend != '0) ? S_EMIT : S_IDLE;
                    ul_next    = up_lvl;
                    left_next  = cur_lvl;
                    if (last_col)
                    begin
                        col_next = '0;
                        row_next = last_row ? '0 : row_reg + 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                if (m_tready)
                begin
                    pend_next = pend_reg & ~sel_mask;
                    if ((pend_reg & ~sel_mask) == '0)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                pend_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            ul_reg    <= '0;
            left_reg  <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            ul_reg    <= ul_next;
            left_reg  <= left_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (decide)
        begin
            for (int i = 0; i < NRES; i++)
            begin
                res_row_reg[i] <= res_row_next[i];
                res_col_reg[i] <= res_col_next[i];
                res_val_reg[i] <= res_val_next[i];
            end
        end
    end

    assign row_wide = {{COORD_W{1'b0}}, res_row_reg[sel_idx]};
    assign col_wide = {{COORD_W{1'b0}}, res_col_reg[sel_idx]};

    assign m_tvalid = (state_reg == S_EMIT);
    assign m_tlast  = ((pend_reg & ~sel_mask) == '0);
    assign m_tdata  = {{MPAD{1'b0}}, res_val_reg[sel_idx],
                       col_wide[COORD_W-1:0], row_wide[COORD_W-1:0]};

    a_emit_has_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (pend_reg != '0))
        else $error("emit state with no pending result");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while results still go out");

    a_accept_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == S_DIV) && !div_done)
        else $error("accepted beat did not start the divider");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside of the divide state");

    a_pend_only_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) && (state_next == S_EMIT) |=>
        ((pend_reg & ~$past(pend_reg)) == '0))
        else $error("pending results grew during emission");

endmodule

@@ dv/tb_level_contour_map.sv @@
`timescale 1ns / 1ps
module tb_level_contour_map;
    import lcm_pkg::*;

    localparam int MAX_W        = DEF_MAX_WIDTH;
    localparam int MAX_H        = DEF_MAX_HEIGHT;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int IDLE_PAUSE   = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 380;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [VAL_W-1:0]   value;
        logic               last;
    } contour_beat_t;

    typedef enum int {PAT_NOISE, PAT_FLAT, PAT_RAMP, PAT_BLOCKS} pix_pattern_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [31:0]       m_tdata;
    logic              m_tlast;

    // register shadow, reset values
    logic [GEOM_W-1:0] row_length_reg = ROW_LENGTH_RST;
    logic [GEOM_W-1:0] row_total_reg  = ROW_TOTAL_RST;
    logic [VAL_W-1:0]  equidist_reg   = EQUIDIST_RST;
    logic [VAL_W-1:0]  contour_reg    = CONTOUR_RST;
    logic [VAL_W-1:0]  backgr_reg     = BACKGROUND_RST;

    // level state mirrored from the block
    logic [LVL_W-1:0]  line_levels [MAX_W];
    logic [LVL_W-1:0]  left_lvl = '0;
    logic [LVL_W-1:0]  upper_left_lvl = '0;
    int                col_cnt = 0;
    int                row_cnt = 0;

    contour_beat_t     contour_beats_due [$];

    int  mismatch_cnt = 0;
    int  beats_checked = 0;
    int  pixels_sent = 0;
    int  random_items = 0;
    int  frames_run = 0;
    int  cycle_cnt = 0;
    int  hold_requests = 0;
    int  holds_done = 0;
    int  stall_left = 0;
    bit  tx_gaps = 1'b0;
    bit  rx_stalls = 1'b0;

    level_contour_map dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still due", cycle_cnt,
                     contour_beats_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(0, 2);
        else if (r < 96)
            return $urandom_range(3, 12);
        return $urandom_range(20, 70);
    endfunction

    function automatic int clamp_int(int v, int lo, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic contour_beat_t make_beat(int r, int c, logic is_contour);
        contour_beat_t b;
        b.row   = COORD_W'(r);
        b.col   = COORD_W'(c);
        b.value = is_contour ? contour_reg : backgr_reg;
        b.last  = 1'b0;
        return b;
    endfunction

    // quantize one pixel and decide every output pixel whose neighbors are now known
    function automatic void quantize_and_mark(input logic [7:0] pix);
        int               w;
        int               h;
        int               x;
        int               y;
        int               n;
        logic             last_col;
        logic             last_row;
        logic [LVL_W-1:0] cur;
        logic [LVL_W-1:0] upper;
        logic [LVL_W-1:0] ul;
        logic [LVL_W-1:0] left;
        contour_beat_t    found [4];
        w = clamp_int(int'(row_length_reg), 1, MAX_W);
        h = clamp_int(int'(row_total_reg), 1, MAX_H);
        x = col_cnt;
        y = row_cnt;
        n = 0;
        // a counter past a shrunken edge counts as sitting on it
        last_col = (x + 1 >= w);
        last_row = (y + 1 >= h);
        if (x >= MAX_W)
            x = MAX_W - 1;
        cur   = LVL_W'(int'(pix) / clamp_int(int'(equidist_reg), 2, 255));
        upper = line_levels[x];
        ul    = upper_left_lvl;
        left  = left_lvl;
        if (y >= 1 && x >= 1)
        begin
            found[n] = make_beat(y - 1, x - 1, ul != upper || ul != left);
            n++;
        end
        if (y >= 1 && last_col)
        begin
            found[n] = make_beat(y - 1, x, upper != cur);
            n++;
        end
        if (last_row && x >= 1)
        begin
            found[n] = make_beat(y, x - 1, left != cur);
            n++;
        end
        if (last_row && last_col)
        begin
            found[n] = make_beat(y, x, 1'b0);
            n++;
        end
        for (int i = 0; i < n; i++)
        begin
            found[i].last = (i == n - 1);
            contour_beats_due.push_back(found[i]);
        end
        line_levels[x] = cur;
        upper_left_lvl = upper;
        left_lvl       = cur;
        if (last_col)
        begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : y + 1;
        end
        else
            col_cnt = x + 1;
    endfunction

    function automatic logic [7:0] make_pixel(pix_pattern_t pat, int x, int y, logic [7:0] base);
        case (pat)
            PAT_NOISE:  return 8'($urandom);
            PAT_FLAT:   return 8'(base + $urandom_range(0, 3));
            PAT_RAMP:   return 8'(base + x * 9 + y * 5);
            PAT_BLOCKS: return (((x / 3) + (y / 2)) % 2 == 1) ? base : ~base;
            default:    return base;
        endcase
    endfunction

    // output side: random stalls plus one long hold per request
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (holds_done != hold_requests)
        begin
            m_tready   <= 1'b0;
            stall_left <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
        else if (rx_stalls && $urandom_range(0, 3) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap();
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_beats
        contour_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_checked++;
            if (contour_beats_due.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected beat: row %0d col %0d value %0d last %0b",
                             m_tdata[9:0], m_tdata[19:10], m_tdata[27:20], m_tlast);
            end
            else
            begin
                want = contour_beats_due.pop_front();
                if (m_tdata[9:0] !== want.row || m_tdata[19:10] !== want.col ||
                    m_tdata[27:20] !== want.value || m_tdata[31:28] !== 4'h0 ||
                    m_tlast !== want.last)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                    begin
                        $display("beat mismatch: expected row %0d col %0d value %0d last %0b",
                                 want.row, want.col, want.value, want.last);
                        $display("  got row %0d col %0d value %0d last %0b pad %h",
                                 m_tdata[9:0], m_tdata[19:10], m_tdata[27:20], m_tlast,
                                 m_tdata[31:28]);
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [REG_IW-1:0] idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ROW_LENGTH: row_length_reg = value[GEOM_W-1:0];
            REG_ROW_TOTAL:  row_total_reg  = value[GEOM_W-1:0];
            REG_EQUIDIST:   equidist_reg   = value[VAL_W-1:0];
            REG_CONTOUR:    contour_reg    = value[VAL_W-1:0];
            REG_BACKGROUND: backgr_reg     = value[VAL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_pixel(input logic [7:0] pix);
        int gap;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap)
            begin
                s_tdata <= 8'($urandom);
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do
            @(posedge clk);
        while (!s_tready);
        quantize_and_mark(pix);
        pixels_sent++;
    endtask

    // stop offering, let every due beat arrive, then cover a pixel still in the divider
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (contour_beats_due.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    task automatic program_all(int len, int total, int eq, int cv, int bv);
        wait_idle();
        write_reg(REG_ROW_LENGTH, APB_DW'(len));
        write_reg(REG_ROW_TOTAL, APB_DW'(total));
        write_reg(REG_EQUIDIST, APB_DW'(eq));
        write_reg(REG_CONTOUR, APB_DW'(cv));
        write_reg(REG_BACKGROUND, APB_DW'(bv));
    endtask

    // shrink to 1x1 mid-frame so the next pixel wraps both counters
    task automatic close_frame();
        if (col_cnt != 0 || row_cnt != 0)
        begin
            wait_idle();
            write_reg(REG_ROW_LENGTH, APB_DW'(1));
            write_reg(REG_ROW_TOTAL, APB_DW'(1));
            send_pixel(8'($urandom));
        end
    endtask

    // reset geometry is 1024 x 1024: a short first row, then shrink width and height under it
    task automatic test_wide_then_shrink();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h01);
        send_pixel(8'hFE);
        wait_idle();
        write_reg(REG_ROW_LENGTH, APB_DW'(3));
        write_reg(REG_ROW_TOTAL, APB_DW'(2));
        send_pixel(8'h80);
        send_pixel(8'h7F);
        send_pixel(8'h02);
        send_pixel(8'h03);
        frames_run++;
    endtask

    task automatic test_register_clamping();
        // width above range, height and spacing below; then width and spacing below, height above
        program_all(11'h7FF, 0, 0, 8'h00, 8'hFF);
        send_pixel(8'h04);
        send_pixel(8'h05);
        send_pixel(8'h06);
        close_frame();
        program_all(0, 11'h7FF, 1, 8'h5A, 8'hA5);
        send_pixel(8'h10);
        send_pixel(8'h11);
        send_pixel(8'h12);
        close_frame();
        frames_run += 2;
    endtask

    task automatic test_single_pixel_frames();
        // a lone pixel is always background
        program_all(1, 1, 255, 8'hC3, 8'h3C);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        program_all(2, 2, 255, 8'hC3, 8'h3C);
        send_pixel(8'hFE);
        send_pixel(8'hFF);
        send_pixel(8'hFF);
        send_pixel(8'hFE);
        frames_run += 3;
    endtask

    task automatic test_backpressure();
        program_all(6, 5, 20, 200, 50);
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        hold_requests++;
        for (int i = 0; i < 30; i++)
            send_pixel(make_pixel(PAT_RAMP, i % 6, i / 6, 8'd10));
        // sender waits for every result before going on
        wait_idle();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        program_all(4, 3, 7, 99, 1);
        for (int i = 0; i < 12; i++)
            send_pixel(make_pixel(PAT_BLOCKS, i % 4, i / 4, 8'h35));
        frames_run += 2;
    endtask

    task automatic test_random_frames();
        int           w;
        int           h;
        int           eq;
        int           stop_at;
        int           tweak_at;
        pix_pattern_t pat;
        logic [7:0]   base;
        while (random_items < RANDOM_ITEMS)
        begin
            w  = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 48);
            h  = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 20);
            eq = $urandom_range(0, 9);
            eq = (eq < 5) ? $urandom_range(0, 8) :
                 (eq < 8) ? $urandom_range(9, 64) : $urandom_range(65, 255);
            program_all(w, h, eq, $urandom_range(0, 255), $urandom_range(0, 255));
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            pat  = pix_pattern_t'($urandom_range(0, 3));
            base = 8'($urandom);
            stop_at  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, w * h) : w * h;
            // keep the item total near the budget
            if (stop_at > RANDOM_ITEMS - random_items)
                stop_at = RANDOM_ITEMS - random_items;
            tweak_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, stop_at) : 0;
            for (int i = 0; i < stop_at; i++)
            begin
                // spacing and output values may change between pixels of a frame
                if (i == tweak_at && i > 0)
                begin
                    wait_idle();
                    write_reg(REG_EQUIDIST, APB_DW'($urandom_range(0, 255)));
                    write_reg(REG_CONTOUR, APB_DW'($urandom_range(0, 255)));
                    write_reg(REG_BACKGROUND, APB_DW'($urandom_range(0, 255)));
                end
                send_pixel(make_pixel(pat, i % w, i / w, base));
                random_items++;
            end
            close_frame();
            frames_run++;
        end
    endtask

    initial
    begin
        foreach (line_levels[i])
            line_levels[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_wide_then_shrink();
        test_register_clamping();
        test_single_pixel_frames();
        test_backpressure();
        test_random_frames();
        wait_idle();
        $display("ran %0d pixels over %0d frames (%0d random), %0d result beats checked",
                 pixels_sent, frames_run, random_items, beats_checked);
        $display("clamped and mid-frame shrunk geometry, long output hold, %0d mismatches",
                 mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
